@@ src/bdh_pkg.sv @@
// Package for the button debouncer with hold timers.
// Holds the configuration record, register indexes, state codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package bdh_pkg;

  localparam int BDH_WINDOW_DEPTH = 5;
  localparam int CNT_W            = 24;
  localparam int PERIOD_W         = 10;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic                RST_PRESSED_LEVEL = 1'b0;
  localparam logic [PERIOD_W-1:0] RST_TICK_PERIOD   = 10'd10;
  localparam logic [CNT_W-1:0]    RST_PRESSED_LIMIT = 24'd60000;
  localparam logic [CNT_W-1:0]    RST_RELEASE_LIMIT = 24'd60000;

  typedef enum logic [1:0] {
    REG_PRESSED_LEVEL = 2'd0,
    REG_TICK_PERIOD   = 2'd1,
    REG_PRESSED_LIMIT = 2'd2,
    REG_RELEASE_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CODE_RELEASED     = 2'd0,
    CODE_PRE_PRESSED  = 2'd1,
    CODE_PRESSED      = 2'd2,
    CODE_PRE_RELEASED = 2'd3
  } btn_code_t;

  typedef enum logic [3:0] {
    ST_RELEASED     = 4'b0001,
    ST_PRE_PRESSED  = 4'b0010,
    ST_PRESSED      = 4'b0100,
    ST_PRE_RELEASED = 4'b1000
  } btn_state_t;

  typedef struct packed {
    logic                pressed_level;
    logic [PERIOD_W-1:0] tick_period_ms;
    logic [CNT_W-1:0]    pressed_limit_ms;
    logic [CNT_W-1:0]    released_limit_ms;
  } cfg_t;

endpackage

@@ src/bdh_cfg_regs.sv @@
// APB-style configuration registers of the button debouncer.
// Depends on bdh_pkg.
`timescale 1ns / 1ps

module bdh_cfg_regs
  import bdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level     <= RST_PRESSED_LEVEL;
      cfg_r.tick_period_ms    <= RST_TICK_PERIOD;
      cfg_r.pressed_limit_ms  <= RST_PRESSED_LIMIT;
      cfg_r.released_limit_ms <= RST_RELEASE_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_PRESSED_LEVEL: cfg_r.pressed_level     <= pwdata[0];
        REG_TICK_PERIOD:   cfg_r.tick_period_ms    <= pwdata[PERIOD_W-1:0];
        REG_PRESSED_LIMIT: cfg_r.pressed_limit_ms  <= pwdata[CNT_W-1:0];
        REG_RELEASE_LIMIT: cfg_r.released_limit_ms <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRESSED_LEVEL: prdata = {{(DATA_W-1){1'b0}}, cfg_r.pressed_level};
      REG_TICK_PERIOD:   prdata = {{(DATA_W-PERIOD_W){1'b0}}, cfg_r.tick_period_ms};
      REG_PRESSED_LIMIT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_r.pressed_limit_ms};
      REG_RELEASE_LIMIT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_r.released_limit_ms};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/bdh_core.sv @@
// Sample window, debounce state machine, hold counters and result register.
// Depends on bdh_pkg.
`timescale 1ns / 1ps

module bdh_core
  import bdh_pkg::*;
#(
  parameter int WINDOW_DEPTH = BDH_WINDOW_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             step,
  input  logic             pin,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_button_state,
  output logic [CNT_W-1:0] out_pressed_ms,
  output logic [CNT_W-1:0] out_released_ms
);

  logic [WINDOW_DEPTH-1:0] window_r, window_nxt;
  btn_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]        rcnt_r, rcnt_nxt;
  logic                    out_valid_r;
  logic [1:0]              code_r;
  logic [CNT_W-1:0]        pms_r, rms_r;
  logic                    lv_p, lv_r;
  logic                    go_pre_press, go_press, go_pre_rel, go_rel;
  logic [1:0]              code_nxt;

  function automatic logic [CNT_W-1:0] grow(input logic [CNT_W-1:0]    cnt,
                                            input logic [CNT_W-1:0]    limit,
                                            input logic [PERIOD_W-1:0] period);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + {{(CNT_W+1-PERIOD_W){1'b0}}, period};
    if (cnt >= limit) begin
      return cnt;
    end else if (sum[CNT_W]) begin
      return CNT_MAX;
    end else begin
      return sum[CNT_W-1:0];
    end
  endfunction

  assign ready     = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_button_state = code_r;
  assign out_pressed_ms   = pms_r;
  assign out_released_ms  = rms_r;

  assign window_nxt = {window_r[WINDOW_DEPTH-2:0], pin};
  assign lv_p = cfg.pressed_level;
  assign lv_r = ~cfg.pressed_level;

  assign go_pre_press = (window_nxt[0] == lv_p) && (window_nxt[1] == lv_p) &&
                        (window_nxt[3] == lv_r) && (window_nxt[4] == lv_r);
  assign go_press     = (window_nxt[0] == lv_p) && (window_nxt[1] == lv_p) &&
                        (window_nxt[2] == lv_p);
  assign go_pre_rel   = (window_nxt[0] == lv_r) && (window_nxt[1] == lv_r) &&
                        (window_nxt[3] == lv_p) && (window_nxt[4] == lv_p);
  assign go_rel       = (window_nxt[0] == lv_r) && (window_nxt[1] == lv_r) &&
                        (window_nxt[2] == lv_r);

  always_comb begin
    state_nxt = state_r;
    pcnt_nxt  = pcnt_r;
    rcnt_nxt  = rcnt_r;
    case (state_r)
      ST_RELEASED: begin
        if (go_pre_press) begin
          state_nxt = ST_PRE_PRESSED;
          rcnt_nxt  = '0;
        end else begin
          rcnt_nxt = grow(rcnt_r, cfg.released_limit_ms, cfg.tick_period_ms);
        end
      end
      ST_PRE_PRESSED: begin
        if (go_press) state_nxt = ST_PRESSED;
      end
      ST_PRESSED: begin
        if (go_pre_rel) begin
          state_nxt = ST_PRE_RELEASED;
          pcnt_nxt  = '0;
        end else begin
          pcnt_nxt = grow(pcnt_r, cfg.pressed_limit_ms, cfg.tick_period_ms);
        end
      end
      ST_PRE_RELEASED: begin
        if (go_rel) state_nxt = ST_RELEASED;
      end
      default: state_nxt = ST_RELEASED;
    endcase
  end

  always_comb begin
    case (state_nxt)
      ST_RELEASED:     code_nxt = CODE_RELEASED;
      ST_PRE_PRESSED:  code_nxt = CODE_PRE_PRESSED;
      ST_PRESSED:      code_nxt = CODE_PRESSED;
      ST_PRE_RELEASED: code_nxt = CODE_PRE_RELEASED;
      default:         code_nxt = CODE_RELEASED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= {WINDOW_DEPTH{~RST_PRESSED_LEVEL}};
      state_r     <= ST_RELEASED;
      pcnt_r      <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        window_r <= window_nxt;
        state_r  <= state_nxt;
        pcnt_r   <= pcnt_nxt;
        rcnt_r   <= rcnt_nxt;
      end
      if (ready) out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      code_r <= code_nxt;
      pms_r  <= pcnt_nxt;
      rms_r  <= rcnt_nxt;
    end
  end

  a_pcnt_only_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_PRESSED |-> pcnt_r == '0)
    else $error("pressed counter nonzero outside pressed state");

  a_rcnt_only_released: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_RELEASED |-> rcnt_r == '0)
    else $error("released counter nonzero outside released state");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(state_r) && $stable(window_r))
    else $error("state moved without an item");

  a_pcnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    step && state_r == ST_PRESSED && state_nxt == ST_PRESSED |=> pcnt_r >= $past(pcnt_r))
    else $error("pressed counter decreased while held");

endmodule

@@ src/button_debounce_with_hold_timers.sv @@
// Top level: input register, configuration registers and debounce core.
// An accepted item passes the input register, then the result register, where the result
// is valid; one item per cycle sustained while out_stall is low, and the window/state/counter
// update loop sets that rate.
// Synchronous active-low reset: window all at the released level, state released,
// counters zero, registers at their defaults. Depends on bdh_pkg, bdh_cfg_regs, bdh_core.
`timescale 1ns / 1ps

module button_debounce_with_hold_timers
  import bdh_pkg::*;
#(
  parameter int WINDOW_DEPTH = BDH_WINDOW_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_pin_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_button_state,
  output logic [CNT_W-1:0]  out_pressed_ms,
  output logic [CNT_W-1:0]  out_released_ms,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic in_valid_r;
  logic pin_r;
  logic core_ready;
  logic step;

  assign in_stall = in_valid_r && !core_ready;
  assign step     = in_valid_r && core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) pin_r <= in_pin_level;
  end

  bdh_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdh_core #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .step             (step),
    .pin              (pin_r),
    .ready            (core_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_button_state (out_button_state),
    .out_pressed_ms   (out_pressed_ms),
    .out_released_ms  (out_released_ms)
  );

endmodule

@@ bench/tb_button_debounce_with_hold_timers.sv @@
// Testbench for button_debounce_with_hold_timers: a directed table, then random runs
// of pin samples under several register settings, checked per item by table or predictor.
// Depends on bdh_pkg and the RTL of button_debounce_with_hold_timers.
`timescale 1ns / 1ps

module tb_button_debounce_with_hold_timers;
  import bdh_pkg::*;

  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 125;
  localparam int          WATCHDOG_LIMIT  = 3000;
  localparam int unsigned LIMIT_TOP       = 16000000;
  localparam int          DIR_ROWS        = 32;

  typedef struct packed {
    btn_code_t        state;
    logic [CNT_W-1:0] pressed;
    logic [CNT_W-1:0] released;
  } result_t;

  typedef struct packed {
    bit                is_write;
    reg_idx_t          idx;
    logic [DATA_W-1:0] wval;
    logic              pin;
    bit                typed;
    btn_code_t         st;
    logic [CNT_W-1:0]  pms;
    logic [CNT_W-1:0]  rms;
  } stim_row_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              in_pin_level = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [1:0]        out_button_state;
  logic [CNT_W-1:0]  out_pressed_ms;
  logic [CNT_W-1:0]  out_released_ms;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state
  cfg_t                        shadow_cfg;
  logic [BDH_WINDOW_DEPTH-1:0] pin_hist;
  btn_code_t                   dbn_state;
  logic [CNT_W-1:0]            hold_pressed;
  logic [CNT_W-1:0]            hold_released;

  result_t expected_reports [$];
  int      mismatch_count = 0;
  int      reports_seen   = 0;
  int      stuck_cycles   = 0;
  int      stall_left     = 0;
  bit      send_idle      = 1'b1;
  bit      recv_idle      = 1'b1;

  stim_row_t dir_tab [DIR_ROWS] = '{
    // reset settings: press, hold, release
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b1, 1'b1, CODE_RELEASED,     24'd0,  24'd10},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b1, 1'b1, CODE_RELEASED,     24'd0,  24'd20},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b0, 1'b1, CODE_RELEASED,     24'd0,  24'd30},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b0, 1'b1, CODE_PRE_PRESSED,  24'd0,  24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b0, 1'b1, CODE_PRESSED,      24'd0,  24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b0, 1'b1, CODE_PRESSED,      24'd10, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b1, 1'b1, CODE_PRESSED,      24'd20, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b1, 1'b1, CODE_PRE_RELEASED, 24'd0,  24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b1, 1'b1, CODE_RELEASED,     24'd0,  24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0, 1'b1, 1'b1, CODE_RELEASED,     24'd0,  24'd10},
    // limit overshoot
    '{1'b1, REG_TICK_PERIOD,   32'd7,  1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b1, REG_RELEASE_LIMIT, 32'd25, 1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,  1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,  1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,  1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,  1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    // zero period, counter below a top limit
    '{1'b1, REG_TICK_PERIOD,   32'd0,         1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b1, REG_RELEASE_LIMIT, 32'd16000000,  1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,         1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,         1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,         1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    // polarity flip with samples in the window, pressed limit zero
    '{1'b1, REG_TICK_PERIOD,   32'd1000, 1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b1, REG_PRESSED_LIMIT, 32'd0,    1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b1, REG_PRESSED_LEVEL, 32'd1,    1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b1, 1'b0, CODE_RELEASED, 24'd0, 24'd0},
    '{1'b0, REG_PRESSED_LEVEL, 32'd0,    1'b0, 1'b0, CODE_RELEASED, 24'd0, 24'd0}
  };

  button_debounce_with_hold_timers dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_button_state (out_button_state),
    .out_pressed_ms   (out_pressed_ms),
    .out_released_ms  (out_released_ms),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] add_hold(input logic [CNT_W-1:0] cnt,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] sum;
    if (cnt >= lim) return cnt;
    sum = {1'b0, cnt} + {{(CNT_W+1-PERIOD_W){1'b0}}, shadow_cfg.tick_period_ms};
    if (sum > {1'b0, CNT_MAX}) return CNT_MAX;
    return sum[CNT_W-1:0];
  endfunction

  function automatic result_t debounce_step(input logic pin);
    logic    p;
    logic    r;
    result_t res;
    p = shadow_cfg.pressed_level;
    r = ~p;
    pin_hist = {pin_hist[BDH_WINDOW_DEPTH-2:0], pin};
    case (dbn_state)
      CODE_RELEASED: begin
        if (pin_hist[0] == p && pin_hist[1] == p && pin_hist[3] == r && pin_hist[4] == r) begin
          hold_released = '0;
          dbn_state = CODE_PRE_PRESSED;
        end else begin
          hold_released = add_hold(hold_released, shadow_cfg.released_limit_ms);
        end
      end
      CODE_PRE_PRESSED: begin
        if (pin_hist[0] == p && pin_hist[1] == p && pin_hist[2] == p) dbn_state = CODE_PRESSED;
      end
      CODE_PRESSED: begin
        if (pin_hist[0] == r && pin_hist[1] == r && pin_hist[3] == p && pin_hist[4] == p) begin
          hold_pressed = '0;
          dbn_state = CODE_PRE_RELEASED;
        end else begin
          hold_pressed = add_hold(hold_pressed, shadow_cfg.pressed_limit_ms);
        end
      end
      default: begin
        if (pin_hist[0] == r && pin_hist[1] == r && pin_hist[2] == r) dbn_state = CODE_RELEASED;
      end
    endcase
    res.state = dbn_state;
    res.pressed = hold_pressed;
    res.released = hold_released;
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  function automatic logic [DATA_W-1:0] rand_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return LIMIT_TOP;
      2: return $urandom_range(300);
      3: return $urandom_range(5000);
      default: return $urandom_range(LIMIT_TOP);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_period();
    case ($urandom_range(3))
      0: return 1;
      1: return 1000;
      2: return $urandom_range(20, 1);
      default: return $urandom_range(1000, 1);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t item %0d: %s", $time, reports_seen, msg);
    mismatch_count++;
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PRESSED_LEVEL: shadow_cfg.pressed_level     = val[0];
      REG_TICK_PERIOD:   shadow_cfg.tick_period_ms    = val[PERIOD_W-1:0];
      REG_PRESSED_LIMIT: shadow_cfg.pressed_limit_ms  = val[CNT_W-1:0];
      default:           shadow_cfg.released_limit_ms = val[CNT_W-1:0];
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_pin(input logic lvl, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = send_idle ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pin_level <= lvl;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = debounce_step(lvl);
    expected_reports.push_back(typed ? want : pred);
  endtask

  task automatic program_phase(input int ph);
    logic [DATA_W-1:0] lvl;
    logic [DATA_W-1:0] per;
    logic [DATA_W-1:0] plim;
    logic [DATA_W-1:0] rlim;
    lvl  = $urandom_range(1);
    per  = rand_period();
    plim = rand_limit();
    rlim = rand_limit();
    if (ph == 0) begin
      lvl = 1; per = 1; plim = '0; rlim = '0;
    end else if (ph == 1) begin
      lvl = 0; per = 1000; plim = LIMIT_TOP; rlim = LIMIT_TOP;
    end else if (ph == 2) begin
      per = 1000; plim = $urandom_range(200); rlim = $urandom_range(200);
    end
    apb_write(REG_PRESSED_LEVEL, lvl);
    apb_write(REG_TICK_PERIOD, per);
    apb_write(REG_PRESSED_LIMIT, plim);
    apb_write(REG_RELEASE_LIMIT, rlim);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (recv_idle && $urandom_range(3) == 0) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch("item with none expected");
      end else begin
        want = expected_reports.pop_front();
        if (out_button_state != want.state)
          report_mismatch($sformatf("button_state got %0d want %0d", out_button_state,
                                    want.state));
        if (out_pressed_ms != want.pressed)
          report_mismatch($sformatf("pressed_ms got %0d want %0d", out_pressed_ms,
                                    want.pressed));
        if (out_released_ms != want.released)
          report_mismatch($sformatf("released_ms got %0d want %0d", out_released_ms,
                                    want.released));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    result_t want;
    int      ph;
    int      n;
    int      k;
    int      run_len;
    logic    run_lvl;
    shadow_cfg.pressed_level     = RST_PRESSED_LEVEL;
    shadow_cfg.tick_period_ms    = RST_TICK_PERIOD;
    shadow_cfg.pressed_limit_ms  = RST_PRESSED_LIMIT;
    shadow_cfg.released_limit_ms = RST_RELEASE_LIMIT;
    pin_hist      = {BDH_WINDOW_DEPTH{~RST_PRESSED_LEVEL}};
    dbn_state     = CODE_RELEASED;
    hold_pressed  = '0;
    hold_released = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_write) begin
        wait_drained();
        apb_write(dir_tab[i].idx, dir_tab[i].wval);
      end else begin
        want.state    = dir_tab[i].st;
        want.pressed  = dir_tab[i].pms;
        want.released = dir_tab[i].rms;
        send_pin(dir_tab[i].pin, dir_tab[i].typed, want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      program_phase(ph);
      send_idle = ($urandom_range(3) != 0);
      recv_idle = ($urandom_range(3) != 0);
      run_lvl   = 1'($urandom_range(1));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(40) == 0) wait_drained();
        if ($urandom_range(99) < 75) begin
          // clean press or release run
          run_len = $urandom_range(25, 3);
          for (k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
            send_pin(run_lvl, 1'b0, '0);
            n++;
          end
          run_lvl = ~run_lvl;
        end else begin
          // contact bounce
          run_len = $urandom_range(2, 1);
          for (k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
            send_pin(1'($urandom_range(1)), 1'b0, '0);
            n++;
          end
        end
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bdh_pkg.sv
src/bdh_cfg_regs.sv
src/bdh_core.sv
src/button_debounce_with_hold_timers.sv
bench/tb_button_debounce_with_hold_timers.sv
